// ----- rtl/core/cmas_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the centered moving average smoother.
// No dependencies; every other file of the block uses this package.
package cmas_pkg;

  localparam int unsigned SampleW      = 8;   // record sample and result width
  localparam int unsigned PtsW         = 5;   // smoothing_points register width
  localparam int unsigned CfgIdxW      = 2;   // configuration register index width
  localparam int unsigned CfgDataW     = 5;   // configuration write data width
  localparam int unsigned MaxSmoothing = 16;  // default upper bound on N

  typedef enum logic [CfgIdxW-1:0] {
    RegPoints = 2'd0,
    RegEnable = 2'd1
  } cfg_reg_e;

endpackage

// ----- rtl/core/cmas_in_if.sv -----
`timescale 1ns / 1ps
// Sample input channel: valid/ready handshake carrying one record sample.
// Depends on cmas_pkg for the sample width.
interface cmas_in_if;
  logic                         valid;
  logic                         ready;
  logic [cmas_pkg::SampleW-1:0] sample;
  logic                         end_of_record;

  modport source(output valid, sample, end_of_record, input ready);
  modport sink(input valid, sample, end_of_record, output ready);
endinterface

// ----- rtl/core/cmas_out_if.sv -----
`timescale 1ns / 1ps
// Result output channel: valid/ready handshake carrying one smoothed point.
// Depends on cmas_pkg for the sample width.
interface cmas_out_if;
  logic                         valid;
  logic                         ready;
  logic [cmas_pkg::SampleW-1:0] smoothed;
  logic                         last_out;

  modport source(output valid, smoothed, last_out, input ready);
  modport sink(input valid, smoothed, last_out, output ready);
endinterface

// ----- rtl/core/cmas_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on cmas_pkg for the index and data widths.
interface cmas_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cmas_pkg::CfgIdxW-1:0]  index;
  logic [cmas_pkg::CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/cmas_hist_mem.sv -----
`timescale 1ns / 1ps
// Sample history ring: one write port, one read port, registered read data.
// Depends on cmas_pkg for the sample width.
module cmas_hist_mem #(
  parameter int unsigned MAX_SMOOTHING = cmas_pkg::MaxSmoothing,
  localparam int unsigned Depth = MAX_SMOOTHING + 1,
  localparam int unsigned PtrW  = $clog2(Depth)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [PtrW-1:0]              waddr_i,
  input  logic [cmas_pkg::SampleW-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [PtrW-1:0]              raddr_i,
  output logic [cmas_pkg::SampleW-1:0] rdata_o
);
  import cmas_pkg::*;

  logic [SampleW-1:0] mem_q [Depth];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cmas_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider: window sum over sample count, one quotient bit a cycle.
// Depends on cmas_pkg for the sample width.
module cmas_div #(
  parameter int unsigned MAX_SMOOTHING = cmas_pkg::MaxSmoothing,
  localparam int unsigned CntW  = $clog2(MAX_SMOOTHING + 2),
  localparam int unsigned SumW  = cmas_pkg::SampleW + CntW,
  localparam int unsigned StepW = $clog2(SumW + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [SumW-1:0]              dividend_i,
  input  logic [CntW-1:0]              divisor_i,
  output logic                         done_o,
  output logic [cmas_pkg::SampleW-1:0] quot_o
);
  import cmas_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  dsr_q, dsr_d;
  logic [CntW:0]    trial;

  assign trial = {rem_q, quo_q[SumW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = CntW'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  // Average never exceeds one sample; keep the low byte.
  assign quot_o = quo_q[SampleW-1:0];
  assign done_o = done_q;

endmodule

// ----- rtl/core/cmas_ctrl.sv -----
`timescale 1ns / 1ps
// Point sequencer: writes samples to the history ring, reads each window term by
// term, accumulates sum and count and hands them to the divider. Uses cmas_pkg.
module cmas_ctrl #(
  parameter int unsigned MAX_SMOOTHING = cmas_pkg::MaxSmoothing,
  localparam int unsigned Depth = MAX_SMOOTHING + 1,
  localparam int unsigned PtrW  = $clog2(Depth),
  localparam int unsigned CntW  = $clog2(MAX_SMOOTHING + 2),
  localparam int unsigned SumW  = cmas_pkg::SampleW + CntW,
  localparam int unsigned HW    = $clog2(MAX_SMOOTHING / 2 + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cmas_pkg::SampleW-1:0] sample_i,
  input  logic                         eor_i,
  input  logic [cmas_pkg::PtsW-1:0]    pts_i,
  input  logic                         en_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [cmas_pkg::SampleW-1:0] res_smoothed_o,
  output logic                         res_last_o,
  output logic                         mem_we_o,
  output logic [PtrW-1:0]              mem_waddr_o,
  output logic [cmas_pkg::SampleW-1:0] mem_wdata_o,
  output logic                         mem_re_o,
  output logic [PtrW-1:0]              mem_raddr_o,
  input  logic [cmas_pkg::SampleW-1:0] mem_rdata_i,
  output logic                         div_start_o,
  output logic [SumW-1:0]              div_dividend_o,
  output logic [CntW-1:0]              div_divisor_o,
  input  logic                         div_done_i,
  input  logic [cmas_pkg::SampleW-1:0] div_quot_i
);
  import cmas_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StPass    = 3'd1;
  localparam logic [2:0] StSum     = 3'd2;
  localparam logic [2:0] StWait    = 3'd3;
  localparam logic [2:0] StDivGo   = 3'd4;
  localparam logic [2:0] StDivWait = 3'd5;
  localparam logic [2:0] StEmit    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [PtrW-1:0]    wp_q, wp_d;
  logic [CntW-1:0]    seen_q, seen_d;
  logic [PtrW-1:0]    newest_q, newest_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [HW-1:0]      h_q, h_d;
  logic [HW-1:0]      j_q, j_d;
  logic               odd_q, odd_d;
  logic               last_q, last_d;
  logic [SampleW-1:0] sample_q, sample_d;
  logic [CntW-1:0]    t_q, t_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               rd_pend_q, rd_inc_q;

  // Per-item decode of the live settings.
  logic [CntW-1:0] npts_eff;
  logic            pass_mode;
  logic [HW-1:0]   h_new;
  logic [CntW-1:0] n_new;
  logic            accept;

  // Term decode for the current window read.
  logic [CntW-1:0] jw, hw, d, lag, t_last;
  logic            term_inc, pair_ok;
  logic [CntW:0]   addr_wide;

  assign accept = in_valid_i && (state_q == StIdle);

  always_comb begin
    if (32'(pts_i) > MAX_SMOOTHING) begin
      npts_eff = CntW'(MAX_SMOOTHING);
    end else begin
      npts_eff = CntW'(pts_i);
    end
    pass_mode = !en_i || (npts_eff < CntW'(2));
    h_new     = HW'(npts_eff >> 1);
    n_new     = (seen_q < CntW'(Depth)) ? seen_q + CntW'(1) : seen_q;
  end

  // Term t of point j: t=0 is the sample itself, odd/even t in 1..2H are the
  // pair at distance (t+1)/2, t=2H+1 is the extra leading sample for odd N.
  always_comb begin
    jw      = CntW'(j_q);
    hw      = CntW'(h_q);
    d       = (t_q >> 1) + CntW'(t_q[0]);
    t_last  = (hw << 1) + CntW'(1);
    pair_ok = (d <= jw) && ((jw + d) <= (n_q - CntW'(1)));
    term_inc = 1'b0;
    lag      = '0;
    if (t_q == '0) begin
      term_inc = 1'b1;
      lag      = jw;
    end else if (t_q == t_last) begin
      term_inc = odd_q && (jw >= hw);
      lag      = term_inc ? jw - hw : '0;
    end else begin
      term_inc = pair_ok;
      if (pair_ok) begin
        lag = t_q[0] ? jw - d : jw + d;
      end
    end
    if (lag <= CntW'(newest_q)) begin
      addr_wide = {1'b0, CntW'(newest_q) - lag};
    end else begin
      addr_wide = (CntW + 1)'(newest_q) + (CntW + 1)'(Depth) - {1'b0, lag};
    end
  end

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    seen_d   = seen_q;
    newest_d = newest_q;
    n_d      = n_q;
    h_d      = h_q;
    j_d      = j_q;
    odd_d    = odd_q;
    last_d   = last_q;
    sample_d = sample_q;
    t_d      = t_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;

    // Fold in the sample read in the previous cycle.
    if (rd_pend_q && rd_inc_q) begin
      sum_d = sum_q + SumW'(mem_rdata_i);
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          newest_d = wp_q;
          n_d      = n_new;
          h_d      = h_new;
          odd_d    = npts_eff[0];
          last_d   = eor_i;
          sample_d = sample_i;
          t_d      = '0;
          sum_d    = '0;
          cnt_d    = '0;
          if (eor_i) begin
            wp_d   = '0;
            seen_d = '0;
          end else begin
            wp_d   = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + PtrW'(1);
            seen_d = n_new;
          end
          if (pass_mode) begin
            state_d = StPass;
          end else if (eor_i) begin
            // Flush every pending point, oldest first.
            j_d     = ((n_new - CntW'(1)) < CntW'(h_new)) ? HW'(n_new - CntW'(1)) : h_new;
            state_d = StSum;
          end else if (n_new > CntW'(h_new)) begin
            j_d     = h_new;
            state_d = StSum;
          end
        end
      end
      StPass: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      StSum: begin
        if (term_inc) begin
          cnt_d = cnt_q + CntW'(1);
        end
        t_d = t_q + CntW'(1);
        if (t_q == t_last) begin
          state_d = StWait;
        end
      end
      StWait: begin
        state_d = StDivGo;
      end
      StDivGo: begin
        state_d = StDivWait;
      end
      StDivWait: begin
        if (div_done_i) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (res_ready_i) begin
          if (last_q && (j_q != '0)) begin
            j_d     = j_q - HW'(1);
            t_d     = '0;
            sum_d   = '0;
            cnt_d   = '0;
            state_d = StSum;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      wp_q      <= '0;
      seen_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      seen_q    <= seen_d;
      rd_pend_q <= (state_q == StSum);
    end
  end

  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
    n_q      <= n_d;
    h_q      <= h_d;
    j_q      <= j_d;
    odd_q    <= odd_d;
    last_q   <= last_d;
    sample_q <= sample_d;
    t_q      <= t_d;
    sum_q    <= sum_d;
    cnt_q    <= cnt_d;
    rd_inc_q <= term_inc;
  end

  assign in_ready_o = (state_q == StIdle);

  // The write lands at the accept edge; reads start in the following cycle, so no
  // read ever overlaps a write to the same slot.
  assign mem_we_o    = accept;
  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = sample_i;
  assign mem_re_o    = (state_q == StSum);
  assign mem_raddr_o = PtrW'(addr_wide);

  assign div_start_o    = (state_q == StDivGo);
  assign div_dividend_o = sum_q;
  assign div_divisor_o  = cnt_q;

  assign res_valid_o    = (state_q == StPass) || (state_q == StEmit);
  assign res_smoothed_o = (state_q == StPass) ? sample_q : div_quot_i;
  assign res_last_o     = (state_q == StPass) ? last_q : (last_q && (j_q == '0));

endmodule

// ----- rtl/core/centered_moving_average_smoother_top.sv -----
`timescale 1ns / 1ps
// Centered moving average smoother, top level. A smoothed point takes one history
// read per window term, then a bit-serial divide of the SumW-bit window sum (SumW =
// 8 + clog2(MAX_SMOOTHING+2), 13 by default). A non-final item gives at most one
// point; the final item flushes up to H+1 points back to back. Reset clears
// control and settings (N = 1, smoothing off); the history memory needs no
// clearing, only current-record slots are read.
module centered_moving_average_smoother_top #(
  parameter int unsigned MAX_SMOOTHING = cmas_pkg::MaxSmoothing
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmas_in_if.sink    smp_i,
  cmas_out_if.source res_o,
  cmas_cfg_if.sink   cfg_i
);
  import cmas_pkg::*;

  localparam int unsigned Depth = MAX_SMOOTHING + 1;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(MAX_SMOOTHING + 2);
  localparam int unsigned SumW  = SampleW + CntW;

  // Settings registers.
  logic [PtsW-1:0] pts_q;
  logic            en_q;

  // Sequencer result beat into the output register.
  logic               res_valid, res_ready, res_last;
  logic [SampleW-1:0] res_smoothed;

  // Output register.
  logic               out_valid_q;
  logic [SampleW-1:0] out_smoothed_q;
  logic               out_last_q;

  // History memory port.
  logic               mem_we, mem_re;
  logic [PtrW-1:0]    mem_waddr, mem_raddr;
  logic [SampleW-1:0] mem_wdata, mem_rdata;

  // Divider port.
  logic               div_start, div_done;
  logic [SumW-1:0]    div_dividend;
  logic [CntW-1:0]    div_divisor;
  logic [SampleW-1:0] div_quot;

  // Configuration: always ready; the user sends writes only while the block is idle,
  // which the block does not enforce. Drop writes to indexes outside the register list.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= PtsW'(1);
      en_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegPoints: pts_q <= cfg_i.data[PtsW-1:0];
        RegEnable: en_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  cmas_ctrl #(
    .MAX_SMOOTHING(MAX_SMOOTHING)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (smp_i.valid),
    .in_ready_o    (smp_i.ready),
    .sample_i      (smp_i.sample),
    .eor_i         (smp_i.end_of_record),
    .pts_i         (pts_q),
    .en_i          (en_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_smoothed_o(res_smoothed),
    .res_last_o    (res_last),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .div_start_o   (div_start),
    .div_dividend_o(div_dividend),
    .div_divisor_o (div_divisor),
    .div_done_i    (div_done),
    .div_quot_i    (div_quot)
  );

  cmas_hist_mem #(
    .MAX_SMOOTHING(MAX_SMOOTHING)
  ) u_hist_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  cmas_div #(
    .MAX_SMOOTHING(MAX_SMOOTHING)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Output register: load a new beat when empty or when the held one leaves,
  // so the sequencer can take the next sample while a result waits.
  assign res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_smoothed_q <= res_smoothed;
      out_last_q     <= res_last;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.smoothed = out_smoothed_q;
  assign res_o.last_out = out_last_q;

`ifndef SYNTHESIS
  // The sequencer never presents a point while it can take a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !smp_i.ready)
    else $error("sequencer ready while presenting a point");

  // A point blocked by a full output register holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_smoothed) && $stable(res_last))
    else $error("stalled point changed");

  // A start and a finish of the divider never coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_done)
    else $error("divider restarted while finishing");
`endif

endmodule
